// ----- src/assert_macros.svh -----
// assertion macros used by the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted (active-low reset)
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/sldbv_pkg.sv -----
// types and constants for the sequential list with delete by value
// no dependencies
`default_nettype none

package sldbv_pkg;

    localparam int DEF_CAPACITY = 128;

    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 8;

    // request modes
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDWAIT,
        S_SEARCH,
        S_SHIFT
    } t_state;

endpackage

`default_nettype wire

// ----- src/sequential_list_delete_by_value.sv -----
// top level: bounded list of signed 32-bit values with append, delete by value and read
// depends on sldbv_pkg
`default_nettype none

// A request is taken on a rising edge with i_start high and o_busy low. Each request
// gives exactly one result, shown for one cycle with o_valid high; the receiver cannot
// stall, so it must take every result as it comes. Append and mode 3 give their result
// the cycle after the transfer and leave o_busy low. Read raises o_busy in S_RDWAIT while
// its memory data comes back; a read out of range answers at once like an append.
// Delete walks the list in one memory of CAPACITY words with one
// read and one write per cycle: a pipelined search compares one entry a cycle, then the
// later entries are moved down one place a cycle. A delete and an in-range read keep
// o_busy high until done, and their result comes in the same cycle that o_busy drops.
// The memory is not cleared after reset; only entries below the length are ever read.
module sequential_list_delete_by_value #(
    parameter int CAPACITY = sldbv_pkg::DEF_CAPACITY
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    output logic                                  o_busy,
    input  wire         [sldbv_pkg::MODE_W-1:0]   i_mode,
    input  wire  signed [sldbv_pkg::VALUE_W-1:0]  i_value,
    input  wire         [sldbv_pkg::INDEX_W-1:0]  i_index,
    output logic                                  o_valid,
    output logic        [sldbv_pkg::STATUS_W-1:0] o_status,
    output logic        [sldbv_pkg::LEN_W-1:0]    o_length_now,
    output logic signed [sldbv_pkg::VALUE_W-1:0]  o_read_data
);
    import sldbv_pkg::*;

    // address width and count width (count must reach CAPACITY itself)
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // width for comparing the read index against the count
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // list storage, one read and one write port, registered read data
    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] r_mem_q;

    t_state r_state, n_state;

    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_ptr, n_ptr;     // next entry to read during search and shift
    logic [AW-1:0]      r_wp, n_wp;       // entry to write during shift
    logic               r_pend, n_pend;   // a read was issued last cycle
    logic [VALUE_W-1:0] r_value, n_value; // value being deleted

    logic                r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [VALUE_W-1:0]  r_data, n_data;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    logic idx_ok;
    logic hit;
    logic more;

    assign idx_ok = IW'(i_index) < IW'(r_count);
    // returning read data matches the value being deleted
    assign hit    = r_pend && (r_mem_q == r_value);
    // entries still left to read
    assign more   = r_ptr < r_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_mode)
                        MODE_DELETE: n_state = S_SEARCH;
                        MODE_READ:   n_state = idx_ok ? S_RDWAIT : S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_RDWAIT: n_state = S_IDLE;
            S_SEARCH: begin
                if (hit) begin
                    n_state = S_SHIFT;
                end else if (!more) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (!more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory control and result
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wp;
        mem_wdata = r_mem_q;
        mem_re    = 1'b0;
        mem_raddr = r_ptr[AW-1:0];

        n_count  = r_count;
        n_ptr    = r_ptr;
        n_wp     = r_wp;
        n_pend   = r_pend;
        n_value  = r_value;
        n_valid  = 1'b0;
        n_status = r_status;
        n_len    = r_len;
        n_data   = r_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_mode)
                        MODE_APPEND: begin
                            n_valid = 1'b1;
                            n_data  = '0;
                            if (r_count == CAP_CNT) begin
                                n_status = STAT_FULL;
                                n_len    = LEN_W'(r_count);
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = i_value;
                                n_count   = r_count + 1'b1;
                                n_status  = STAT_OK;
                                n_len     = LEN_W'(r_count + 1'b1);
                            end
                        end
                        MODE_DELETE: begin
                            n_value = i_value;
                            n_ptr   = '0;
                            n_pend  = 1'b0;
                        end
                        MODE_READ: begin
                            if (idx_ok) begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(i_index);
                            end else begin
                                n_valid  = 1'b1;
                                n_status = STAT_RANGE;
                                n_len    = LEN_W'(r_count);
                                n_data   = '0;
                            end
                        end
                        default: begin
                            // code without meaning: answer ok, list untouched
                            n_valid  = 1'b1;
                            n_status = STAT_OK;
                            n_len    = LEN_W'(r_count);
                            n_data   = '0;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_valid  = 1'b1;
                n_status = STAT_OK;
                n_len    = LEN_W'(r_count);
                n_data   = r_mem_q;
            end
            S_SEARCH: begin
                if (hit) begin
                    // match sits one behind the read pointer
                    n_wp   = AW'(r_ptr - 1'b1);
                    n_pend = 1'b0;
                end else if (!more) begin
                    n_valid  = 1'b1;
                    n_status = STAT_NOT_FOUND;
                    n_len    = LEN_W'(r_count);
                    n_data   = '0;
                    n_pend   = 1'b0;
                end else begin
                    mem_re = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_SHIFT: begin
                // write back the entry read last cycle one place lower
                if (r_pend) begin
                    mem_we = 1'b1;
                    n_wp   = r_wp + 1'b1;
                end
                if (more) begin
                    mem_re = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend   = 1'b0;
                    n_count  = r_count - 1'b1;
                    n_valid  = 1'b1;
                    n_status = STAT_OK;
                    n_len    = LEN_W'(r_count - 1'b1);
                    n_data   = '0;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // list memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_wp     <= n_wp;
        r_value  <= n_value;
        r_status <= n_status;
        r_len    <= n_len;
        r_data   <= n_data;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_length_now = r_len;
    assign o_read_data  = signed'(r_data);

endmodule

`default_nettype wire

// ----- src/sldbv_check.sv -----
// port-level checks for the sequential list, with the bind that attaches them
// depends on sldbv_pkg, assert_macros.svh and the top level
`default_nettype none

`include "assert_macros.svh"

module sldbv_check #(
    parameter int CAPACITY = sldbv_pkg::DEF_CAPACITY
) (
    input wire                                   i_clk,
    input wire                                   i_rst_n,
    input wire                                   i_start,
    input wire                                   o_busy,
    input wire         [sldbv_pkg::MODE_W-1:0]   i_mode,
    input wire  signed [sldbv_pkg::VALUE_W-1:0]  i_value,
    input wire         [sldbv_pkg::INDEX_W-1:0]  i_index,
    input wire                                   o_valid,
    input wire         [sldbv_pkg::STATUS_W-1:0] o_status,
    input wire         [sldbv_pkg::LEN_W-1:0]    o_length_now,
    input wire  signed [sldbv_pkg::VALUE_W-1:0]  o_read_data
);
    import sldbv_pkg::*;

    logic unused_fields;
    assign unused_fields = ^{i_mode, i_value, i_index};

    // a full report only comes from a list at capacity
    `CHK_ASSERT(a_full_len, i_clk, i_rst_n, (o_valid && o_status == STAT_FULL) |-> (o_length_now == LEN_W'(CAPACITY)), "full reported below capacity")

    // only a good read carries data
    `CHK_ASSERT(a_data_zero, i_clk, i_rst_n, (o_valid && o_status != STAT_OK) |-> (o_read_data == '0), "data on a failed request")

    // a result follows a transfer or a busy cycle
    `CHK_ASSERT(a_valid_cause, i_clk, i_rst_n, o_valid |-> ($past(i_start) || $past(o_busy)), "result without a request")

    // a long request ends with its result
    `CHK_ASSERT(a_busy_end, i_clk, i_rst_n, $fell(o_busy) |-> o_valid, "busy dropped without a result")

endmodule

bind sequential_list_delete_by_value sldbv_check #(
    .CAPACITY(CAPACITY)
) u_sldbv_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .i_mode       (i_mode),
    .i_value      (i_value),
    .i_index      (i_index),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_length_now (o_length_now),
    .o_read_data  (o_read_data)
);

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the bounded list with append, delete by value and read
// depends on sldbv_pkg and sequential_list_delete_by_value
// requests come from a prebuilt queue, results are checked against a list kept in the bench
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sldbv_pkg::*;

    localparam int CAP         = DEF_CAPACITY;
    localparam int N_RANDOM    = 900;
    localparam int CYCLE_LIMIT = 800000;

    // the fourth mode code has no meaning and must leave the list alone
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct {
        logic        [MODE_W-1:0]  mode;
        logic signed [VALUE_W-1:0] value;
        logic        [INDEX_W-1:0] index;
    } list_req_t;

    typedef struct {
        logic        [STATUS_W-1:0] status;
        logic        [LEN_W-1:0]    length_now;
        logic signed [VALUE_W-1:0]  read_data;
    } list_resp_t;

    // dut ports, all inputs known from time zero
    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_start = 1'b0;
    logic        [MODE_W-1:0]    i_mode  = '0;
    logic signed [VALUE_W-1:0]   i_value = '0;
    logic        [INDEX_W-1:0]   i_index = '0;
    logic                        o_busy;
    logic                        o_valid;
    logic        [STATUS_W-1:0]  o_status;
    logic        [LEN_W-1:0]     o_length_now;
    logic signed [VALUE_W-1:0]   o_read_data;

    sequential_list_delete_by_value uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_index      (i_index),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_length_now (o_length_now),
        .o_read_data  (o_read_data)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bench-side copy of the list, updated once per accepted transfer
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] list_words [CAP];
    int                        list_len = 0;

    function automatic list_resp_t apply_request(list_req_t rq);
        list_resp_t rs;
        int         hit;
        rs.status    = STAT_OK;
        rs.read_data = '0;
        case (rq.mode)
            MODE_APPEND: begin
                if (list_len >= CAP) begin
                    rs.status = STAT_FULL;
                end else begin
                    list_words[list_len] = rq.value;
                    list_len++;
                end
            end
            MODE_DELETE: begin
                hit = -1;
                for (int i = 0; i < list_len; i++) begin
                    if (hit < 0 && list_words[i] == rq.value) hit = i;
                end
                if (hit < 0) begin
                    rs.status = STAT_NOT_FOUND;
                end else begin
                    // close the gap left by the first match
                    for (int i = hit; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            MODE_READ: begin
                if (int'(rq.index) < list_len) rs.read_data = list_words[rq.index];
                else rs.status = STAT_RANGE;
            end
            default: ;
        endcase
        rs.length_now = LEN_W'(list_len);
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building; a shadow of the list steers deletes to values present
    // ------------------------------------------------------------------
    list_req_t                 req_fifo [$];
    logic signed [VALUE_W-1:0] shadow_vals [$];

    task automatic add_req(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value,
                           logic [INDEX_W-1:0] index);
        list_req_t rq;
        int        hit;
        rq.mode  = mode;
        rq.value = value;
        rq.index = index;
        req_fifo.push_back(rq);
        if (mode == MODE_APPEND && shadow_vals.size() < CAP) begin
            shadow_vals.push_back(value);
        end else if (mode == MODE_DELETE) begin
            hit = -1;
            foreach (shadow_vals[i]) if (hit < 0 && shadow_vals[i] == value) hit = i;
            if (hit >= 0) shadow_vals.delete(hit);
        end
    endtask

    // small pool gives plenty of duplicates, so first-match order is exercised
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return VALUE_W'(int'($urandom_range(0, 9)) - 5);
        if (r < 50) begin
            case ($urandom_range(0, 3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_present();
        if (shadow_vals.size() == 0) return pick_value();
        return shadow_vals[$urandom_range(0, shadow_vals.size() - 1)];
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if (shadow_vals.size() > 0 && $urandom_range(0, 4) != 0)
            return INDEX_W'($urandom_range(0, shadow_vals.size() - 1));
        return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
    endfunction

    task automatic build_directed();
        add_req(MODE_READ,   '0, '0);           // read on empty list
        add_req(MODE_DELETE, 32'sd5, '0);       // delete on empty list
        add_req(MODE_NONE,   '1, '1);           // meaningless mode, all ones
        add_req(MODE_APPEND, VAL_MAX, '0);
        add_req(MODE_APPEND, VAL_MIN, '1);
        add_req(MODE_APPEND, '0, '0);
        add_req(MODE_APPEND, '1, '0);
        add_req(MODE_APPEND, 32'sd7, '0);
        add_req(MODE_APPEND, 32'sd7, '0);       // duplicate
        add_req(MODE_READ,   '0, 7'd0);
        add_req(MODE_READ,   '0, 7'd1);
        add_req(MODE_READ,   '0, 7'd4);
        add_req(MODE_READ,   '0, 7'd6);         // index equal to length
        add_req(MODE_READ,   '0, '1);           // highest index
        add_req(MODE_DELETE, 32'sd7, '0);       // only the first of the two goes
        add_req(MODE_READ,   '0, 7'd4);
        add_req(MODE_DELETE, VAL_MIN, '0);      // middle entry
        add_req(MODE_DELETE, 32'sd12345, '0);   // no match
        add_req(MODE_DELETE, VAL_MAX, '0);      // first entry
        add_req(MODE_DELETE, 32'sd7, '0);       // last entry
        add_req(MODE_READ,   '0, 7'd1);
        add_req(MODE_READ,   '0, 7'd2);
    endtask

    task automatic build_random(int n_items);
        int  last;
        int  target;
        int  r;
        int  n;
        bit  first_fill;
        last       = req_fifo.size() + n_items;
        first_fill = 1'b1;
        while (req_fifo.size() < last) begin
            r = $urandom_range(0, 99);
            if (first_fill || r < 35) begin
                // fill phase, a third of them right up to a full list
                target = (first_fill || $urandom_range(0, 2) == 0)
                       ? CAP : $urandom_range(shadow_vals.size(), CAP);
                first_fill = 1'b0;
                while (shadow_vals.size() < target) begin
                    if ($urandom_range(0, 9) == 0) add_req(MODE_READ, pick_value(), pick_index());
                    else add_req(MODE_APPEND, pick_value(), pick_index());
                end
                if (target == CAP) begin
                    repeat ($urandom_range(1, 3)) add_req(MODE_APPEND, pick_value(), pick_index());
                    add_req(MODE_READ, pick_value(), INDEX_W'(CAP - 1));
                end
            end else if (r < 65) begin
                // drain phase, mostly deletes of values present
                n = $urandom_range(1, shadow_vals.size() + 3);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    if (r < 15) add_req(MODE_READ, pick_value(), pick_index());
                    else if (r < 25) add_req(MODE_DELETE, pick_value(), pick_index());
                    else add_req(MODE_DELETE, pick_present(), pick_index());
                end
            end else begin
                // loose mix, noise included
                repeat (24) begin
                    r = $urandom_range(0, 99);
                    if (r < 35) add_req(MODE_APPEND, pick_value(), pick_index());
                    else if (r < 50) add_req(MODE_DELETE, pick_present(), pick_index());
                    else if (r < 65) add_req(MODE_DELETE, pick_value(), pick_index());
                    else if (r < 95) add_req(MODE_READ, pick_value(), pick_index());
                    else add_req(MODE_NONE, pick_value(), pick_index());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: changes inputs on the falling edge, holds a request until taken
    // ------------------------------------------------------------------
    int n_issued   = 0;
    int n_accepted = 0;
    int gap_left   = 0;
    int burst_left = 0;

    // mostly short gaps, some long ones, and now and then a run with none
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        list_req_t nxt;
        // nothing moves until the last request issued has been transferred
        if (i_rst_n && n_accepted == n_issued) begin
            if (gap_left == 0 && req_fifo.size() > 0) begin
                nxt = req_fifo.pop_front();
                i_start <= 1'b1;
                i_mode  <= nxt.mode;
                i_value <= nxt.value;
                i_index <= nxt.index;
                n_issued++;
                gap_left = pick_gap();
            end else begin
                // idle: junk on the payload, which must be ignored
                if (gap_left > 0) gap_left--;
                i_start <= 1'b0;
                i_mode  <= MODE_W'($urandom_range(0, 3));
                i_value <= $urandom;
                i_index <= INDEX_W'($urandom);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: samples on the rising edge, checks results, logs transfers
    // ------------------------------------------------------------------
    list_resp_t due_results [$];
    int         n_errors = 0;
    int         n_results = 0;
    int         mode_seen [4]   = '{default: 0};
    int         status_seen [4] = '{default: 0};
    int         longest = 0;

    always @(posedge i_clk) begin
        list_req_t  rq;
        list_resp_t want;
        if (i_rst_n) begin
            // results first; a result never comes on the edge of its own transfer
            if (o_valid) begin
                n_results++;
                if (due_results.size() == 0) begin
                    $error("result with nothing outstanding: status %0d length %0d data %0d",
                           o_status, o_length_now, o_read_data);
                    n_errors++;
                end else begin
                    want = due_results.pop_front();
                    status_seen[o_status]++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        n_errors++;
                    end
                    if (o_length_now !== want.length_now) begin
                        $error("length_now: expected %0d, got %0d",
                               want.length_now, o_length_now);
                        n_errors++;
                    end
                    if (o_read_data !== want.read_data) begin
                        $error("read_data: expected %0d, got %0d", want.read_data, o_read_data);
                        n_errors++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                rq.mode  = i_mode;
                rq.value = i_value;
                rq.index = i_index;
                due_results.push_back(apply_request(rq));
                mode_seen[i_mode]++;
                if (list_len > longest) longest = list_len;
                n_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    int n_cycles = 0;

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     n_cycles, due_results.size());
            $display("tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence: build stimulus, reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        foreach (list_words[i]) list_words[i] = '0;
        build_directed();
        build_random(N_RANDOM);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_fifo.size() != 0 || n_accepted != n_issued || due_results.size() != 0)
            @(negedge i_clk);
        // all results are in; leave room for stray results
        repeat (CAP + 10) @(posedge i_clk);

        $display("summary: %0d requests (%0d append, %0d delete, %0d read, %0d unused mode)",
                 n_accepted, mode_seen[MODE_APPEND], mode_seen[MODE_DELETE],
                 mode_seen[MODE_READ], mode_seen[MODE_NONE]);
        $display("summary: %0d results (ok %0d, not found %0d, full %0d, range %0d), longest %0d",
                 n_results, status_seen[STAT_OK], status_seen[STAT_NOT_FOUND],
                 status_seen[STAT_FULL], status_seen[STAT_RANGE], longest);
        if (n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
